>>> src/lmg_pkg.sv
package lmg_pkg;

  localparam logic [23:0] POLE_RESET   = 24'd16759746;
  localparam logic [31:0] TGT_MAX      = 32'h8000_0000;
  localparam logic [31:0] TGT_MIN      = 32'd13422;
  localparam logic [16:0] STRENGTH_ONE = 17'd65536;
  localparam logic [31:0] EXP_ONE      = 32'h4000_0000;

  localparam logic [1:0] CH_DRY = 2'd0;
  localparam logic [1:0] CH_WET = 2'd1;
  localparam logic [1:0] CH_DC  = 2'd2;
  localparam int unsigned NUM_CHAINS = 3;

  localparam logic [5:0] DIV_LAST  = 6'd61;
  localparam logic [5:0] SQRT_LAST = 6'd31;
  localparam logic [5:0] LOG_LAST  = 6'd23;
  localparam logic [5:0] EXP_LAST  = 6'd29;
  localparam int unsigned EXP_STEPS = 30;

  typedef logic [EXP_STEPS-1:0][31:0] root_tab_t;

  // Successive square roots of 2 in Q30: 2^(1/2), 2^(1/4), ... (floor)
  function automatic root_tab_t build_roots();
    root_tab_t   tab;
    logic [63:0] r;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    tab = '0;
    r   = 64'd1 << 31;
    for (int i = 0; i < EXP_STEPS; i++) begin
      v   = r << 30;
      res = '0;
      b   = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
        if (v >= res + b) begin
          v   = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      r      = res;
      tab[i] = r[31:0];
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = build_roots();

  typedef enum logic [3:0] {
    ST_IDLE, ST_SM_MUL, ST_SM_ADD, ST_DECIDE, ST_DIV, ST_SQRT, ST_CLAMP, ST_NORM,
    ST_LOG, ST_EXP_MUL, ST_EXP, ST_EXP_FIN, ST_G_MUL, ST_G_ADD, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_SM_MUL, OP_SM_ADD, OP_DECIDE, OP_DIV, OP_SQRT, OP_CLAMP, OP_NORM,
    OP_LOG, OP_EXP_MUL, OP_EXP, OP_EXP_FIN, OP_G_MUL, OP_G_ADD
  } dp_op_t;

  typedef struct packed {
    logic       load;
    dp_op_t     op;
    logic [1:0] chain;
    logic [5:0] cnt;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic silence;
    logic need_tgt;
    logic big;
    logic unity;
    logic normed;
  } stat_t;

endpackage

>>> src/lmg_ctrl.sv
module lmg_ctrl #(
  parameter int unsigned SMOOTH_STAGES = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 out_free,
  input  lmg_pkg::stat_t       stat,
  output lmg_pkg::cmd_t        cmd,
  output logic [((SMOOTH_STAGES > 1) ? $clog2(SMOOTH_STAGES) : 1)-1:0] stage,
  output logic                 idle,
  output logic                 push
);

  localparam int unsigned SW = (SMOOTH_STAGES > 1) ? $clog2(SMOOTH_STAGES) : 1;

  lmg_pkg::state_t state_r, state_nxt;
  logic [1:0]      chain_r, chain_nxt;
  logic [SW-1:0]   stage_r, stage_nxt;
  logic [5:0]      cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmg_pkg::ST_IDLE;
      chain_r <= '0;
      stage_r <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      chain_r <= chain_nxt;
      stage_r <= stage_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    chain_nxt = chain_r;
    stage_nxt = stage_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = lmg_pkg::OP_NONE;
    cmd.chain = chain_r;
    cmd.cnt   = cnt_r;
    idle      = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      lmg_pkg::ST_IDLE: begin
        idle     = 1'b1;
        cmd.load = start;
        if (start) begin
          state_nxt = lmg_pkg::ST_SM_MUL;
          chain_nxt = lmg_pkg::CH_DRY;
          stage_nxt = '0;
        end
      end
      lmg_pkg::ST_SM_MUL: begin
        cmd.op    = lmg_pkg::OP_SM_MUL;
        state_nxt = lmg_pkg::ST_SM_ADD;
      end
      lmg_pkg::ST_SM_ADD: begin
        cmd.op    = lmg_pkg::OP_SM_ADD;
        state_nxt = lmg_pkg::ST_SM_MUL;
        if (stage_r == SW'(SMOOTH_STAGES - 1)) begin
          stage_nxt = '0;
          if (chain_r == lmg_pkg::CH_DC) begin
            state_nxt = lmg_pkg::ST_DECIDE;
          end else begin
            chain_nxt = chain_r + 2'd1;
          end
        end else begin
          stage_nxt = stage_r + SW'(1);
        end
      end
      lmg_pkg::ST_DECIDE: begin
        cmd.op  = lmg_pkg::OP_DECIDE;
        cnt_nxt = '0;
        if (!stat.need_tgt) begin
          state_nxt = lmg_pkg::ST_G_MUL;
        end else if (stat.big) begin
          state_nxt = lmg_pkg::ST_CLAMP;
        end else begin
          state_nxt = lmg_pkg::ST_DIV;
        end
      end
      lmg_pkg::ST_DIV: begin
        cmd.op   = lmg_pkg::OP_DIV;
        cmd.last = (cnt_r == lmg_pkg::DIV_LAST);
        if (cmd.last) begin
          cnt_nxt   = '0;
          state_nxt = lmg_pkg::ST_SQRT;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      lmg_pkg::ST_SQRT: begin
        cmd.op   = lmg_pkg::OP_SQRT;
        cmd.last = (cnt_r == lmg_pkg::SQRT_LAST);
        if (cmd.last) begin
          cnt_nxt   = '0;
          state_nxt = lmg_pkg::ST_CLAMP;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      lmg_pkg::ST_CLAMP: begin
        cmd.op    = lmg_pkg::OP_CLAMP;
        state_nxt = stat.unity ? lmg_pkg::ST_G_MUL : lmg_pkg::ST_NORM;
      end
      lmg_pkg::ST_NORM: begin
        cmd.op = lmg_pkg::OP_NORM;
        if (stat.normed) begin
          cnt_nxt   = '0;
          state_nxt = lmg_pkg::ST_LOG;
        end
      end
      lmg_pkg::ST_LOG: begin
        cmd.op   = lmg_pkg::OP_LOG;
        cmd.last = (cnt_r == lmg_pkg::LOG_LAST);
        if (cmd.last) begin
          cnt_nxt   = '0;
          state_nxt = lmg_pkg::ST_EXP_MUL;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      lmg_pkg::ST_EXP_MUL: begin
        cmd.op    = lmg_pkg::OP_EXP_MUL;
        cnt_nxt   = '0;
        state_nxt = lmg_pkg::ST_EXP;
      end
      lmg_pkg::ST_EXP: begin
        cmd.op   = lmg_pkg::OP_EXP;
        cmd.last = (cnt_r == lmg_pkg::EXP_LAST);
        if (cmd.last) begin
          cnt_nxt   = '0;
          state_nxt = lmg_pkg::ST_EXP_FIN;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      lmg_pkg::ST_EXP_FIN: begin
        cmd.op    = lmg_pkg::OP_EXP_FIN;
        state_nxt = lmg_pkg::ST_G_MUL;
      end
      lmg_pkg::ST_G_MUL: begin
        cmd.op    = lmg_pkg::OP_G_MUL;
        state_nxt = lmg_pkg::ST_G_ADD;
      end
      lmg_pkg::ST_G_ADD: begin
        cmd.op    = lmg_pkg::OP_G_ADD;
        state_nxt = lmg_pkg::ST_DONE;
      end
      lmg_pkg::ST_DONE: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = lmg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lmg_pkg::ST_IDLE;
      end
    endcase
  end

  assign stage = stage_r;

endmodule

>>> src/lmg_dp.sv
module lmg_dp #(
  parameter int unsigned SMOOTH_STAGES = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [23:0]          cfg_wdata,
  input  lmg_pkg::cmd_t        cmd,
  input  logic [((SMOOTH_STAGES > 1) ? $clog2(SMOOTH_STAGES) : 1)-1:0] stage,
  input  logic [31:0]          dry_power,
  input  logic [31:0]          wet_power,
  input  logic [31:0]          dc_power,
  input  logic [16:0]          match_strength,
  input  logic [31:0]          start_gain,
  output lmg_pkg::stat_t       stat,
  output logic [31:0]          gain,
  output logic                 quiet
);

  localparam int unsigned LAST = SMOOTH_STAGES - 1;

  logic [23:0] pole_r;
  logic [31:0] stg_r [lmg_pkg::NUM_CHAINS][SMOOTH_STAGES];
  logic [31:0] gain_r;

  logic [31:0] dry_in_r, wet_in_r, dc_in_r, start_r;
  logic [16:0] str_r;
  logic [31:0] carry_r, target_r;
  logic signed [57:0] prod_r;
  logic [31:0] var_r, rem_r;
  logic [7:0]  nb_r;
  logic [61:0] quo_r;
  logic [63:0] sq_src_r;
  logic [31:0] root_r;
  logic [33:0] srem_r;
  logic [31:0] x_r;
  logic [4:0]  m_r;
  logic [23:0] frac_r;
  logic signed [47:0] e_r;
  logic [31:0] y_r;

  logic [31:0] dry_s, wet_s, dc_s, var_c;
  logic        is_gain;
  logic [31:0] v_in, sm_s, sm_v, sm_new;
  logic signed [32:0] diff;
  logic signed [24:0] pole_s;
  logic signed [57:0] prod_c;
  logic signed [33:0] sm_sum;
  logic [32:0] r2;
  logic        ge;
  logic [31:0] rem_n;
  logic [61:0] quo_n;
  logic [35:0] s2, trial;
  logic        sge;
  logic [33:0] srem_n;
  logic [31:0] root_n;
  logic [31:0] tc;
  logic [63:0] sq;
  logic [32:0] s33;
  logic signed [29:0] l_c;
  logic signed [47:0] e_c;
  logic        ebit;
  logic [63:0] ym;
  logic signed [8:0] k;
  logic [8:0]  shamt;
  logic [31:0] pw;

  assign dry_s = stg_r[lmg_pkg::CH_DRY][LAST];
  assign wet_s = stg_r[lmg_pkg::CH_WET][LAST];
  assign dc_s  = stg_r[lmg_pkg::CH_DC][LAST];
  assign var_c = (wet_s > dc_s) ? (wet_s - dc_s) : '0;

  assign stat.silence  = (dry_s == '0) && (wet_s == '0);
  assign stat.need_tgt = (dry_s != '0) && (var_c != '0);
  assign stat.big      = {8'd0, dry_s} >= {var_c, 8'd0};
  assign stat.unity    = (str_r == lmg_pkg::STRENGTH_ONE);
  assign stat.normed   = x_r[31];

  // One-pole step written as v + p*(s - v) / 2^24, one multiply
  assign is_gain = (cmd.op == lmg_pkg::OP_G_MUL) || (cmd.op == lmg_pkg::OP_G_ADD);

  always_comb begin
    case (cmd.chain)
      lmg_pkg::CH_DRY: v_in = dry_in_r;
      lmg_pkg::CH_WET: v_in = wet_in_r;
      default:         v_in = dc_in_r;
    endcase
  end

  assign sm_s   = is_gain ? gain_r : stg_r[cmd.chain][stage];
  assign sm_v   = is_gain ? target_r : ((stage == '0) ? v_in : carry_r);
  assign diff   = $signed({1'b0, sm_s}) - $signed({1'b0, sm_v});
  assign pole_s = $signed({1'b0, pole_r});
  assign prod_c = pole_s * diff;
  assign sm_sum = $signed({2'b00, sm_v}) + 34'(prod_r >>> 24);
  assign sm_new = sm_sum[31:0];

  // Restoring divider, one quotient bit per step
  assign r2    = {rem_r, nb_r[7]};
  assign ge    = r2 >= {1'b0, var_r};
  assign rem_n = ge ? 32'(r2 - {1'b0, var_r}) : r2[31:0];
  assign quo_n = {quo_r[60:0], ge};

  // Bit-pair square root
  assign s2     = {srem_r, sq_src_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign sge    = s2 >= trial;
  assign srem_n = sge ? 34'(s2 - trial) : s2[33:0];
  assign root_n = {root_r[30:0], sge};

  assign tc = (target_r < lmg_pkg::TGT_MIN) ? lmg_pkg::TGT_MIN : target_r;

  // log2 by repeated squaring of the normalized mantissa
  assign sq  = x_r * x_r;
  assign s33 = sq[63:31];

  assign l_c  = $signed({6'($signed({1'b0, m_r}) - 6'sd27), frac_r});
  assign e_c  = l_c * $signed({1'b0, str_r});
  assign ebit = e_r[6'd39 - cmd.cnt];
  assign ym   = y_r * lmg_pkg::ROOT_TAB[cmd.cnt[4:0]];

  assign k     = 9'($signed(e_r[47:40])) - 9'sd3;
  assign shamt = 9'(-k);

  always_comb begin
    if (k > 9'sd1) begin
      pw = 32'hFFFF_FFFF;
    end else if (k == 9'sd1) begin
      pw = y_r[31] ? 32'hFFFF_FFFF : {y_r[30:0], 1'b0};
    end else if (k == 9'sd0) begin
      pw = y_r;
    end else if (shamt >= 9'd32) begin
      pw = '0;
    end else begin
      pw = y_r >> shamt[4:0];
    end
  end

  always_comb begin
    quiet = 1'b1;
    for (int c = 0; c < lmg_pkg::NUM_CHAINS; c++) begin
      for (int s = 0; s < SMOOTH_STAGES; s++) begin
        if (stg_r[c][s] != '0) quiet = 1'b0;
      end
    end
  end

  assign gain = gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_r <= lmg_pkg::POLE_RESET;
      gain_r <= '0;
      for (int c = 0; c < lmg_pkg::NUM_CHAINS; c++) begin
        for (int s = 0; s < SMOOTH_STAGES; s++) begin
          stg_r[c][s] <= '0;
        end
      end
    end else begin
      if (cfg_we) pole_r <= cfg_wdata;
      case (cmd.op)
        lmg_pkg::OP_SM_ADD: stg_r[cmd.chain][stage] <= sm_new;
        lmg_pkg::OP_DECIDE: if (stat.silence) gain_r <= start_r;
        lmg_pkg::OP_G_ADD:  gain_r <= sm_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dry_in_r <= dry_power;
      wet_in_r <= wet_power;
      dc_in_r  <= dc_power;
      str_r    <= match_strength;
      start_r  <= start_gain;
    end
    case (cmd.op) inside
      lmg_pkg::OP_SM_MUL, lmg_pkg::OP_G_MUL: prod_r <= prod_c;
      lmg_pkg::OP_SM_ADD: carry_r <= sm_new;
      lmg_pkg::OP_DECIDE: begin
        if (stat.silence) begin
          target_r <= start_r;
        end else if (stat.need_tgt && stat.big) begin
          target_r <= lmg_pkg::TGT_MAX;
        end else begin
          target_r <= gain_r;
        end
        rem_r <= {8'd0, dry_s[31:8]};
        nb_r  <= dry_s[7:0];
        quo_r <= '0;
        var_r <= var_c;
      end
      lmg_pkg::OP_DIV: begin
        rem_r <= rem_n;
        nb_r  <= {nb_r[6:0], 1'b0};
        quo_r <= quo_n;
        if (cmd.last) begin
          sq_src_r <= {2'b00, quo_n};
          root_r   <= '0;
          srem_r   <= '0;
        end
      end
      lmg_pkg::OP_SQRT: begin
        sq_src_r <= {sq_src_r[61:0], 2'b00};
        root_r   <= root_n;
        srem_r   <= srem_n;
        if (cmd.last) target_r <= root_n;
      end
      lmg_pkg::OP_CLAMP: begin
        target_r <= tc;
        x_r      <= tc;
        m_r      <= 5'd31;
        frac_r   <= '0;
      end
      lmg_pkg::OP_NORM: begin
        if (!x_r[31]) begin
          x_r <= {x_r[30:0], 1'b0};
          m_r <= m_r - 5'd1;
        end
      end
      lmg_pkg::OP_LOG: begin
        x_r    <= s33[32] ? s33[32:1] : s33[31:0];
        frac_r <= {frac_r[22:0], s33[32]};
      end
      lmg_pkg::OP_EXP_MUL: begin
        e_r <= e_c;
        y_r <= lmg_pkg::EXP_ONE;
      end
      lmg_pkg::OP_EXP:     if (ebit) y_r <= ym[61:30];
      lmg_pkg::OP_EXP_FIN: target_r <= pw;
      default: ;
    endcase
  end

endmodule

>>> src/loudness_match_gain_tracker.sv
// Loudness-match gain tracker. Each input transaction carries dry, wet and
// wet-DC power (unsigned Q8.24), a match strength (Q1.16, 65536 = one) and a
// start gain (Q5.27); each produces exactly one result transaction with the
// smoothed gain (Q5.27) and a flag that is set when every smoother stage is
// zero. The three powers run through SMOOTH_STAGES one-pole stages sharing
// the pole in the configuration register (cfg_we/cfg_wdata, Q0.24); write it
// only while the block is idle. Each item runs every smoother stage through
// the shared one-pole multiplier. When a target gain is formed, the block then
// divides and takes the square root (both skipped for a large ratio), clamps,
// and for a strength other than exactly one also normalizes, runs the log2
// squaring loop and the exp2 root-product loop; the gain is then smoothed
// toward the target on the same multiplier. No target is formed for zero dry
// power or zero variance. The finished result also waits for a free output
// register, and in_stall stays high until it is pushed. The
// result sits in an output register, so a new item is taken while the last
// result waits for the downstream side.
module loudness_match_gain_tracker #(
  parameter int unsigned SMOOTH_STAGES = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_dry_power,
  input  logic [31:0] in_wet_power,
  input  logic [31:0] in_dc_power,
  input  logic [16:0] in_match_strength,
  input  logic [31:0] in_start_gain,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_matched_gain,
  output logic        out_all_quiet
);

  localparam int unsigned SW = (SMOOTH_STAGES > 1) ? $clog2(SMOOTH_STAGES) : 1;

  lmg_pkg::cmd_t  cmd;
  lmg_pkg::stat_t stat;
  logic [SW-1:0]  stage;
  logic           idle, push, in_accept, out_free;
  logic [31:0]    gain;
  logic           quiet;

  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_gain_r;
  logic        out_quiet_r;

  // Take an item only while the sequencer sits idle
  assign in_stall  = !idle;
  assign in_accept = in_valid && !in_stall;

  // Output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  lmg_ctrl #(
    .SMOOTH_STAGES(SMOOTH_STAGES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .out_free (out_free),
    .stat     (stat),
    .cmd      (cmd),
    .stage    (stage),
    .idle     (idle),
    .push     (push)
  );

  lmg_dp #(
    .SMOOTH_STAGES(SMOOTH_STAGES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .stage          (stage),
    .dry_power      (in_dry_power),
    .wet_power      (in_wet_power),
    .dc_power       (in_dc_power),
    .match_strength (in_match_strength),
    .start_gain     (in_start_gain),
    .stat           (stat),
    .gain           (gain),
    .quiet          (quiet)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the finished result; hold it while stalled
  always_ff @(posedge clk) begin
    if (push) begin
      out_gain_r  <= gain;
      out_quiet_r <= quiet;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_matched_gain = out_gain_r;
  assign out_all_quiet    = out_quiet_r;

  // The sequencer must never overwrite a result that is still waiting
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed into a full output register");

  // An accepted transaction keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("block idle right after accepting a transaction");

  // A new result only appears after the block was working
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_stall))
    else $error("result appeared without work in progress");

endmodule
